// File: rtl/pbm_pkg.sv
// package: field widths, command codes and controller/datapath interface types
`timescale 1ns / 1ps

package pbm_pkg;

	localparam int NUM_PAGES_DEF = 4096;
	localparam int WORD_BITS_DEF = 8;

	localparam int CMD_W   = 3;
	localparam int START_W = 12;
	localparam int COUNT_W = 13;

	localparam logic [CMD_W-1:0] CMD_MARK_USED = 3'd0;
	localparam logic [CMD_W-1:0] CMD_MARK_FREE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TEST_USED = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TEST_FREE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND_RUN  = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic clr;     // write one zero word of the clearing pass
		logic load;    // take a command in
		logic scan;    // issue a map read and step the word address
		logic finish;  // capture the walked result
	} pbm_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic quick;
		logic scan_last;
		logic hit;
	} pbm_sts_t;

endpackage

// File: rtl/page_bitmap_allocator_core.sv
// top level: first-fit page bitmap allocator, controller plus datapath
// sequence: no-op, zero-count and off-map commands go from setup straight to done,
//   others walk the map; a range walks every map word it touches, a find stops at a fit
// throughput: one command at a time, busy stays high until the done cycle has passed
// reset: map zeroed one word a cycle with busy high
// done marks a one-cycle result transfer, the receiver cannot stall it
`timescale 1ns / 1ps

module page_bitmap_allocator_core import pbm_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [START_W-1:0] start_page,
	input  logic [COUNT_W-1:0] page_count,
	output logic               done,
	output logic               success,
	output logic [START_W-1:0] found_page,
	output logic               range_error
);

	pbm_ctl_t ctl;
	pbm_sts_t sts;

	pbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	pbm_dpath #(
		.NUM_PAGES (NUM_PAGES),
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.command     (command),
		.start_page  (start_page),
		.page_count  (page_count),
		.sts         (sts),
		.success     (success),
		.found_page  (found_page),
		.range_error (range_error)
	);

endmodule

// File: rtl/pbm_ctrl.sv
// controller: sequences the clearing pass, command setup, map walk and result strobe
`timescale 1ns / 1ps

module pbm_ctrl import pbm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  pbm_sts_t sts,
	output pbm_ctl_t ctl,
	output logic     busy,
	output logic     done
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SETUP,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		ctl        = '0;
		ctl.clr    = (state_q == S_CLEAR);
		ctl.load   = (state_q == S_IDLE) && start && !busy_q;
		ctl.scan   = (state_q == S_SCAN) && !sts.hit;
		ctl.finish = ((state_q == S_SCAN) && sts.hit) || (state_q == S_DRAIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start && !busy_q) begin
						state_q <= S_SETUP;
						busy_q  <= 1'b1;
					end
				end
				S_SETUP: begin
					if (sts.quick) begin
						state_q <= S_DONE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.hit) begin
						state_q <= S_DONE;
						done_q  <= 1'b1;
					end else if (sts.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
					done_q  <= 1'b1;
				end
				S_DONE: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// File: rtl/pbm_dpath.sv
// datapath: page map memory, word walker, range masks and first-fit run tracking
`timescale 1ns / 1ps

module pbm_dpath import pbm_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pbm_ctl_t           ctl,
	input  logic [CMD_W-1:0]   command,
	input  logic [START_W-1:0] start_page,
	input  logic [COUNT_W-1:0] page_count,
	output pbm_sts_t           sts,
	output logic               success,
	output logic [START_W-1:0] found_page,
	output logic               range_error
);

	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int NPW       = $clog2(NUM_PAGES + 1);
	localparam int EW        = (NPW > COUNT_W) ? NPW + 1 : COUNT_W + 1;

	localparam logic [EW-1:0] NUM_E  = EW'(NUM_PAGES);
	localparam logic [AW-1:0] LAST_W = AW'(MAP_WORDS - 1);

	// map storage
	logic [WORD_BITS-1:0] mem_q [MAP_WORDS];

	// walker and command context
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        first_q;
	logic [AW-1:0]        lastw_q;
	logic [BW-1:0]        lo_q;
	logic [BW-1:0]        hi_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [EW-1:0]        count_q;
	logic                 quick_q;
	logic                 fail_q;
	logic [EW-1:0]        run_q;

	// read stage
	logic                 v_s1;
	logic [AW-1:0]        idx_s1;
	logic [WORD_BITS-1:0] rdata_s1;

	// result registers
	logic                 succ_q;
	logic [START_W-1:0]   found_q;
	logic                 err_q;

	// load-time decode
	logic [EW-1:0]        start_e;
	logic [EW-1:0]        count_e;
	logic [EW-1:0]        end_e;
	logic [EW-1:0]        lastpg_e;
	logic                 in_range_cmd;
	logic                 in_find;
	logic                 in_valid;
	logic                 in_zero;
	logic                 in_err;
	logic                 in_quick;
	logic                 in_succ;

	// word processing
	logic [EW-1:0]        base_e;
	logic [BW-1:0]        lo_b;
	logic [BW-1:0]        hi_b;
	logic [WORD_BITS-1:0] rmask;
	logic [WORD_BITS-1:0] used_w;
	logic [WORD_BITS-1:0] hit_v;
	logic [EW-1:0]        run_b [WORD_BITS];
	logic [EW-1:0]        kfree;
	logic                 allfree;
	logic [BW-1:0]        hb;
	logic                 word_fail;
	logic                 fail_next;
	logic                 hit_now;
	logic [EW-1:0]        found_e;
	logic                 is_wr;
	logic [WORD_BITS-1:0] wr_word;
	logic                 we;
	logic [AW-1:0]        wa;
	logic [WORD_BITS-1:0] wd;
	logic                 fin_succ;

	always_comb begin
		start_e      = EW'(start_page);
		count_e      = EW'(page_count);
		end_e        = start_e + count_e;
		lastpg_e     = (end_e > NUM_E) ? NUM_E - EW'(1) : end_e - EW'(1);
		in_range_cmd = (command <= CMD_TEST_FREE);
		in_find      = (command == CMD_FIND_RUN);
		in_valid     = in_range_cmd || in_find;
		in_zero      = (page_count == '0);
		in_err       = in_range_cmd && !in_zero && (end_e > NUM_E);
		in_quick     = !in_valid || in_zero || (in_find && (count_e > NUM_E))
			|| (in_range_cmd && (start_e >= NUM_E));
		// range starting past the map: only the all-used test can hold
		in_succ      = (in_valid && in_zero)
			|| (command == CMD_TEST_USED && start_e >= NUM_E);
	end

	// lane masks for the word in the read stage
	always_comb begin
		base_e = EW'(idx_s1) << BW;
		lo_b   = (idx_s1 == first_q) ? lo_q : '0;
		hi_b   = (idx_s1 == lastw_q) ? hi_q : BW'(WORD_BITS - 1);
		for (int b = 0; b < WORD_BITS; b++) begin
			rmask[b]  = (BW'(b) >= lo_b) && (BW'(b) <= hi_b);
			// pages past the end of the map read as used
			used_w[b] = rdata_s1[b] || ((base_e + EW'(b)) >= NUM_E);
		end
	end

	// free run ending at each lane, carried in from earlier words
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			allfree = 1'b1;
			kfree   = EW'(b + 1);
			for (int j = 0; j < WORD_BITS; j++) begin
				if (j <= b && used_w[j]) begin
					allfree = 1'b0;
					kfree   = EW'(b - j);
				end
			end
			run_b[b] = allfree ? run_q + EW'(b + 1) : kfree;
			hit_v[b] = !used_w[b] && (run_b[b] >= count_q);
		end
		hb = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (hit_v[b]) begin
				hb = BW'(b);
			end
		end
	end

	always_comb begin
		case (cmd_q)
			CMD_TEST_USED: word_fail = |(rmask & ~rdata_s1);
			CMD_TEST_FREE: word_fail = |(rmask & rdata_s1);
			default:       word_fail = 1'b0;
		endcase
		fail_next = fail_q || (v_s1 && word_fail);
		hit_now   = v_s1 && (cmd_q == CMD_FIND_RUN) && (|hit_v);
		found_e   = base_e + EW'(hb) + EW'(1) - count_q;
		is_wr     = (cmd_q == CMD_MARK_USED) || (cmd_q == CMD_MARK_FREE);
		wr_word   = (cmd_q == CMD_MARK_USED) ? (rdata_s1 | rmask) : (rdata_s1 & ~rmask);
		we        = ctl.clr || (v_s1 && is_wr);
		wa        = ctl.clr ? addr_q : idx_s1;
		wd        = ctl.clr ? '0 : wr_word;
		case (cmd_q)
			CMD_MARK_USED, CMD_MARK_FREE: fin_succ = !err_q;
			CMD_TEST_USED:                fin_succ = !fail_next;
			CMD_TEST_FREE:                fin_succ = !fail_next && !err_q;
			CMD_FIND_RUN:                 fin_succ = hit_now;
			default:                      fin_succ = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (ctl.scan) begin
			rdata_s1 <= mem_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			v_s1 <= ctl.scan;
			if (ctl.load) begin
				addr_q <= in_find ? '0 : AW'(start_e >> BW);
			end else if (ctl.clr || ctl.scan) begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			idx_s1 <= addr_q;
		end
		if (ctl.load) begin
			cmd_q   <= command;
			count_q <= count_e;
			quick_q <= in_quick;
			first_q <= in_find ? '0 : AW'(start_e >> BW);
			lastw_q <= in_find ? LAST_W : AW'(lastpg_e >> BW);
			lo_q    <= start_page[BW-1:0];
			hi_q    <= lastpg_e[BW-1:0];
			fail_q  <= 1'b0;
			run_q   <= '0;
			succ_q  <= in_succ;
			found_q <= '0;
			err_q   <= in_err;
		end else begin
			if (v_s1) begin
				fail_q <= fail_next;
				run_q  <= run_b[WORD_BITS-1];
			end
			if (ctl.finish) begin
				succ_q  <= fin_succ;
				found_q <= hit_now ? found_e[START_W-1:0] : '0;
			end
		end
	end

	always_comb begin
		sts           = '0;
		sts.clr_last  = (addr_q == LAST_W);
		sts.quick     = quick_q;
		sts.scan_last = (addr_q == lastw_q);
		sts.hit       = hit_now;
	end

	assign success     = succ_q;
	assign found_page  = found_q;
	assign range_error = err_q;

endmodule
